>>> rtl/ple_pkg.sv
// ple_pkg: shared types, command and status codes for the positional list engine
// no dependencies; used by ple_cell, ple_chain and positional_list_engine_top
`timescale 1ns / 1ps

package ple_pkg;

	localparam int DATA_W        = 32;
	localparam int CMD_W         = 2;
	localparam int POS_W         = 5;
	localparam int STATUS_W      = 3;
	localparam int DEPTH_DEFAULT = 16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

	// per-cell operation codes
	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_INS  = 2'd1;
	localparam logic [1:0] CELL_DEL  = 2'd2;
	localparam logic [1:0] CELL_ROT  = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] operand_value;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    found_position;
		logic [POS_W-1:0]    list_length;
	} result_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

>>> rtl/ple_cell.sv
// ple_cell: one list slot; holds, loads, shifts back, shifts forward or rotates its entry
// depends on ple_pkg
`timescale 1ns / 1ps

module ple_cell #(
	parameter int IDX = 0,
	parameter int IW  = 4
) (
	input  logic                             clk,
	input  ple_pkg::cell_ctl_t               ctl,
	input  logic [IW-1:0]                    k_idx,
	input  logic signed [ple_pkg::DATA_W-1:0] prev_val,
	input  logic signed [ple_pkg::DATA_W-1:0] next_val,
	output logic signed [ple_pkg::DATA_W-1:0] val_q
);
	import ple_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_HOLD: val_q <= val_q;
			CELL_INS: begin
				if (MY_IDX > k_idx) begin
					val_q <= prev_val;
				end else if (MY_IDX == k_idx) begin
					val_q <= ctl.value;
				end
			end
			CELL_DEL: begin
				if (MY_IDX >= k_idx) begin
					val_q <= next_val;
				end
			end
			CELL_ROT: val_q <= next_val;
			default: val_q <= val_q;
		endcase
	end

endmodule

>>> rtl/ple_chain.sv
// ple_chain: ring of DEPTH list cells with the search comparator at the head
// depends on ple_pkg and ple_cell
`timescale 1ns / 1ps

module ple_chain #(
	parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  ple_pkg::cell_ctl_t         ctl,
	input  logic [$clog2(DEPTH)-1:0]   k_idx,
	output logic                       head_match
);
	import ple_pkg::*;

	localparam int IW = $clog2(DEPTH);

	logic signed [DATA_W-1:0] vals [DEPTH];

	// cells wired as a ring so a full rotation restores the list order
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		ple_cell #(
			.IDX (i),
			.IW  (IW)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.k_idx    (k_idx),
			.prev_val (vals[(i + DEPTH - 1) % DEPTH]),
			.next_val (vals[(i + 1) % DEPTH]),
			.val_q    (vals[i])
		);
	end

	assign head_match = (vals[0] == ctl.value);

endmodule

>>> rtl/positional_list_engine_top.sv
// positional list engine: append, insert, delete and search on an ordered list
// append, insert, delete and every rejected command give done in the cycle after they are accepted
// search of a non-empty list gives done once one full rotation of the cell ring has carried every
// entry past the head comparator; busy is high while the ring rotates
// throughput: one transaction per cycle except while busy with a search; results cannot be stalled
// reset clears the length, scan controller and done; list entries are not reset
`timescale 1ns / 1ps

module positional_list_engine_top #(
	parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ple_pkg::cmd_t    command,
	output logic             done,
	output ple_pkg::result_t result
);
	import ple_pkg::*;

	// widths derived from the list depth
	localparam int IW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	// compare width wide enough for count+1 and for the position field
	localparam int LW  = ((CW > POS_W) ? CW : POS_W) + 1;

	// controller states
	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic           state_q;
	logic [CW-1:0]  count_q;
	logic [IW-1:0]  scan_q;
	logic           found_q;
	logic           done_q;
	logic [LW-1:0]  fpos_q;
	logic signed [DATA_W-1:0] key_q;
	result_t        result_q;

	logic           accept;
	logic           head_match;
	cell_ctl_t      ctl;
	logic [IW-1:0]  k_idx;
	logic [CW-1:0]  count_d;
	logic           done_d;
	result_t        res_d;
	logic           scan_start;

	logic           list_full;
	logic [LW-1:0]  cnt_w;
	logic [LW-1:0]  pos_w;
	logic [LW-1:0]  scan_pos;
	logic [LW-1:0]  len_w;
	logic           scan_last;
	logic           hit_now;

	assign accept    = start && !busy;
	assign busy      = (state_q == S_SCAN);
	assign list_full = (count_q == CW'(DEPTH));
	assign cnt_w     = LW'(count_q);
	assign pos_w     = LW'(command.position);
	assign scan_pos  = LW'(scan_q) + LW'(1);
	assign scan_last = (scan_q == IW'(DEPTH - 1));
	// first match only, and only among live entries
	assign hit_now   = !found_q && (LW'(scan_q) < cnt_w) && head_match;

	// command decode and cell control
	always_comb begin
		ctl.op     = CELL_HOLD;
		ctl.value  = command.operand_value;
		k_idx      = '0;
		count_d    = count_q;
		done_d     = 1'b0;
		scan_start = 1'b0;
		res_d      = '0;
		res_d.status = ST_OK;

		if (state_q == S_SCAN) begin
			// rotate the ring one place; the head holds entry scan_q
			ctl.op    = CELL_ROT;
			ctl.value = key_q;
			if (scan_last) begin
				done_d = 1'b1;
				if (found_q || hit_now) begin
					res_d.status         = ST_OK;
					res_d.found_position = found_q ? fpos_q[POS_W-1:0]
						: scan_pos[POS_W-1:0];
				end else begin
					res_d.status = ST_NOTFOUND;
				end
			end
		end else if (accept) begin
			done_d = 1'b1;
			unique case (command.cmd)
				CMD_APPEND: begin
					if (list_full) begin
						res_d.status = ST_FULL;
					end else begin
						ctl.op  = CELL_INS;
						k_idx   = IW'(count_q);
						count_d = count_q + CW'(1);
					end
				end
				CMD_INSERT: begin
					priority if (list_full) begin
						res_d.status = ST_FULL;
					end else if (pos_w == '0 || pos_w > cnt_w + LW'(1)) begin
						res_d.status = ST_RANGE;
					end else begin
						ctl.op  = CELL_INS;
						k_idx   = IW'(pos_w - LW'(1));
						count_d = count_q + CW'(1);
					end
				end
				CMD_DELETE: begin
					priority if (count_q == '0) begin
						res_d.status = ST_EMPTY;
					end else if (pos_w == '0 || pos_w > cnt_w) begin
						res_d.status = ST_RANGE;
					end else begin
						ctl.op  = CELL_DEL;
						k_idx   = IW'(pos_w - LW'(1));
						count_d = count_q - CW'(1);
					end
				end
				CMD_SEARCH: begin
					if (count_q == '0) begin
						res_d.status = ST_EMPTY;
					end else begin
						// result comes after the full rotation
						done_d     = 1'b0;
						scan_start = 1'b1;
					end
				end
				default: res_d.status = ST_OK;
			endcase
		end
	end

	assign len_w             = LW'(count_d);
	// list length is reported after the command
	always_comb begin
		result            = result_q;
		result.list_length = result_q.list_length;
	end

	ple_chain #(
		.DEPTH (DEPTH)
	) u_chain (
		.clk        (clk),
		.ctl        (ctl),
		.k_idx      (k_idx),
		.head_match (head_match)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= done_d;
			if (scan_start) begin
				state_q <= S_SCAN;
				scan_q  <= '0;
				found_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				scan_q <= scan_q + IW'(1);
				if (hit_now) begin
					found_q <= 1'b1;
				end
				if (scan_last) begin
					state_q <= S_IDLE;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (scan_start) begin
			key_q <= command.operand_value;
		end
		if (hit_now) begin
			fpos_q <= scan_pos;
		end
		if (done_d) begin
			result_q <= '{status:         res_d.status,
			              found_position: res_d.found_position,
			              list_length:    len_w[POS_W-1:0]};
		end
	end

	assign done = done_q;

	// result strobe never overlaps a running scan
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && busy))
		else $error("done raised during a search scan");

	// the length never exceeds the list depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("list length beyond depth");

	// a search of a non-empty list starts a scan
	a_search_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command.cmd == CMD_SEARCH && count_q != '0) |=> busy)
		else $error("search did not start a scan");

	// every other transaction answers in the next cycle
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command.cmd != CMD_SEARCH || count_q == '0)) |=> (done && !busy))
		else $error("missing one-cycle result");

	// the scan leaves the list length alone
	a_scan_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(count_q))
		else $error("length changed during a scan");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for positional_list_engine_top, directed cases then random traffic
// depends on ple_pkg and the engine rtl; a shadow list in the bench predicts every result

module tb_top;
	import ple_pkg::*;

	localparam int LIST_DEPTH  = DEPTH_DEFAULT;
	localparam int RAND_ITEMS  = 1200;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_PRINTS  = 40;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    command;
	logic    done;
	result_t result;

	// shadow copy of the list, head at index 0
	logic signed [DATA_W-1:0] shadow_list[$];
	// predicted results, oldest first
	result_t                  pending_results[$];
	int                       error_count = 0;
	int                       cycle_count = 0;
	// random gaps between transactions on the command side
	bit                       gaps_on = 1'b1;

	positional_list_engine_top #(
		.DEPTH(LIST_DEPTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.command(command),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop if the engine hangs or drops results
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL positional_list_engine_top");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// applies one command to the shadow list and returns the result it should give
	function automatic result_t apply_list_cmd(input cmd_t c);
		result_t r;
		int      len;
		int      pos;
		int      i;
		r   = '0;
		len = shadow_list.size();
		pos = int'(c.position);
		r.status = ST_OK;
		case (c.cmd)
			CMD_APPEND: begin
				if (len >= LIST_DEPTH)
					r.status = ST_FULL;
				else
					shadow_list.push_back(c.operand_value);
			end
			CMD_INSERT: begin
				// full is checked ahead of the position
				if (len >= LIST_DEPTH)
					r.status = ST_FULL;
				else if (pos < 1 || pos > len + 1)
					r.status = ST_RANGE;
				else
					shadow_list.insert(pos - 1, c.operand_value);
			end
			CMD_DELETE: begin
				// empty is checked ahead of the position
				if (len == 0)
					r.status = ST_EMPTY;
				else if (pos < 1 || pos > len)
					r.status = ST_RANGE;
				else
					shadow_list.delete(pos - 1);
			end
			default: begin
				if (len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// first match wins
					r.status = ST_NOTFOUND;
					for (i = 0; i < len && r.status == ST_NOTFOUND; i++) begin
						if (shadow_list[i] == c.operand_value) begin
							r.status         = ST_OK;
							r.found_position = POS_W'(i + 1);
						end
					end
				end
			end
		endcase
		r.list_length = POS_W'(shadow_list.size());
		return r;
	endfunction

	// drives one transaction at the falling edge and holds it until the engine takes it;
	// start is left high so back-to-back transactions need no extra edge
	task automatic send_cmd(input logic [CMD_W-1:0] op, input int pos,
			input logic signed [DATA_W-1:0] val);
		cmd_t        c;
		logic [63:0] noise;
		int          idle;
		c.cmd           = op;
		c.position      = pos[POS_W-1:0];
		c.operand_value = val;
		if (gaps_on && $urandom_range(99) < 13) begin
			idle = $urandom_range(1, 3);
			// idle cycles carry junk on the command bus
			repeat (idle) begin
				@(negedge clk);
				noise = {$urandom, $urandom};
				start   <= 1'b0;
				command <= noise[$bits(cmd_t)-1:0];
			end
		end
		@(negedge clk);
		start   <= 1'b1;
		command <= c;
		do @(posedge clk); while (busy);
		pending_results.push_back(apply_list_cmd(c));
	endtask

	// mix of boundary values and full-range random data
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(11))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return 32'sh0000_0000;
			3:       return -32'sd1;
			4:       return 32'sd1;
			5:       return 32'sd42;
			6:       return -32'sd42;
			default: return $urandom;
		endcase
	endfunction

	// compare every strobed result against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with no transaction outstanding: %p", result));
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status)
					report_mismatch($sformatf("status got %0d expected %0d",
						result.status, want.status));
				if (result.found_position !== want.found_position)
					report_mismatch($sformatf("found_position got %0d expected %0d",
						result.found_position, want.found_position));
				if (result.list_length !== want.list_length)
					report_mismatch($sformatf("list_length got %0d expected %0d",
						result.list_length, want.list_length));
			end
		end
	end

	// delete and search on an empty list, inserts out of range
	task automatic test_empty_list();
		send_cmd(CMD_DELETE, 1, 32'sd0);
		send_cmd(CMD_DELETE, 0, 32'sd0);
		send_cmd(CMD_SEARCH, 0, 32'sd0);
		send_cmd(CMD_INSERT, 0, 32'sd5);
		send_cmd(CMD_INSERT, 2, 32'sd5);
	endtask

	// head and tail inserts, then fill to the limit and push past it
	task automatic test_fill_to_full();
		int n;
		send_cmd(CMD_APPEND, 0, 32'sh8000_0000);
		send_cmd(CMD_INSERT, 1, 32'sh7fff_ffff);
		// insert at length+1 lands at the tail
		send_cmd(CMD_INSERT, 3, -32'sd1);
		send_cmd(CMD_INSERT, 31, 32'sd9);
		// duplicate of the second entry, search must report the first one
		send_cmd(CMD_APPEND, 0, 32'sh8000_0000);
		n = 0;
		while (shadow_list.size() < LIST_DEPTH) begin
			if (n[0])
				send_cmd(CMD_APPEND, 0, pick_value());
			else
				send_cmd(CMD_INSERT, $urandom_range(1, shadow_list.size() + 1), pick_value());
			n++;
		end
		send_cmd(CMD_APPEND, 0, 32'sd7);
		send_cmd(CMD_INSERT, 31, 32'sd7);
	endtask

	// searches with hits and a miss, deletes at the edges and outside the list
	task automatic test_search_delete();
		send_cmd(CMD_SEARCH, 0, 32'sh7fff_ffff);
		send_cmd(CMD_SEARCH, 0, 32'sh8000_0000);
		send_cmd(CMD_SEARCH, 0, shadow_list[shadow_list.size() - 1]);
		send_cmd(CMD_SEARCH, 0, 32'sh1357_9bdf);
		send_cmd(CMD_DELETE, 0, 32'sd0);
		send_cmd(CMD_DELETE, 17, 32'sd0);
		send_cmd(CMD_DELETE, 16, 32'sd0);
		send_cmd(CMD_DELETE, 1, 32'sd0);
		send_cmd(CMD_INSERT, shadow_list.size() + 2, 32'sd3);
	endtask

	// random traffic in bursts that grow, drain or churn the list so both ends get hit
	task automatic test_random_mix();
		int                       n;
		int                       mode;
		int                       len;
		int                       roll;
		int                       w_app;
		int                       w_ins;
		int                       w_del;
		int                       pos;
		logic [CMD_W-1:0]         op;
		logic signed [DATA_W-1:0] val;
		mode = 0;
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n % 40 == 0)
				mode = $urandom_range(2);
			// one long quiet stretch with back-to-back transactions
			gaps_on = !(n >= 400 && n < 700);
			case (mode)
				0: begin
					w_app = 35; w_ins = 35; w_del = 10;
				end
				1: begin
					w_app = 10; w_ins = 10; w_del = 55;
				end
				default: begin
					w_app = 20; w_ins = 20; w_del = 25;
				end
			endcase
			len  = shadow_list.size();
			roll = $urandom_range(99);
			if (roll < w_app)
				op = CMD_APPEND;
			else if (roll < w_app + w_ins)
				op = CMD_INSERT;
			else if (roll < w_app + w_ins + w_del)
				op = CMD_DELETE;
			else
				op = CMD_SEARCH;
			// mostly legal positions, some anywhere in the field
			if ($urandom_range(99) < 85) begin
				if (op == CMD_DELETE)
					pos = $urandom_range(1, (len > 0) ? len : 1);
				else
					pos = $urandom_range(1, len + 1);
			end else begin
				pos = $urandom_range(31);
			end
			val = pick_value();
			// searches mostly look for a key that is present
			if (op == CMD_SEARCH && len > 0 && $urandom_range(99) < 60)
				val = shadow_list[$urandom_range(len - 1)];
			send_cmd(op, pos, val);
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		start   = 1'b0;
		command = '0;
		arst_n  = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_fill_to_full();
		test_search_delete();
		test_random_mix();

		@(negedge clk);
		start <= 1'b0;
		// drain, then allow for a full search latency of quiet
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LIST_DEPTH + 4) @(posedge clk);

		if (error_count == 0)
			$display("PASS positional_list_engine_top");
		else
			$display("FAIL positional_list_engine_top");
		$finish;
	end

endmodule

>>> files.f
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_chain.sv
rtl/positional_list_engine_top.sv
tb/sv/tb_top.sv
